### rtl/srcp_pkg.sv
// srcp_pkg: shared types and constants for the scan range to cartesian point unit
// word formats, configuration register map, cordic datapath widths, arctangent table
// no dependencies
`timescale 1ns / 1ps

package srcp_pkg;

  // datapath widths: x/y carry 24 fraction bits (16 of q15.16 plus 8 guard)
  localparam int unsigned XY_W       = 42;
  localparam int unsigned Z_W        = 33;
  localparam int unsigned GUARD_BITS = 8;
  localparam int unsigned MAX_STAGES = 32;

  // cordic gain compensation in q0.32
  localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;

  // quarter turn as a binary angle
  localparam logic signed [31:0] QUARTER_TURN = 32'sh4000_0000;

  // atan(2^-i) as binary angles, rounded to nearest
  localparam logic [31:0] ATAN_TABLE [MAX_STAGES] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

  typedef enum logic [1:0] {
    CFG_START_ANGLE = 2'd0,
    CFG_ANGLE_STEP  = 2'd1,
    CFG_MIN_RANGE   = 2'd2,
    CFG_MAX_RANGE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [30:0] range_sample;
    logic        scan_start;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } out_word_t;

  typedef struct packed {
    logic [31:0] start_angle;
    logic [31:0] angle_step;
    logic [30:0] min_range;
    logic [30:0] max_range;
  } cfg_t;

  // state handed from one cordic cell to the next
  typedef struct packed {
    logic                   valid;
    logic                   flip;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_word_t;

endpackage

### rtl/srcp_front.sv
// srcp_front: beam angle tracking, range window, half-turn fold and gain multiply
// two register stages ahead of the cordic chain
// depends on srcp_pkg
`timescale 1ns / 1ps

module srcp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  accept_i,
  input  srcp_pkg::in_word_t    in_word_i,
  input  srcp_pkg::cfg_t        cfg_i,
  output srcp_pkg::cordic_word_t out_o
);

  logic [31:0]                    beam_angle_q, beam_angle_d;
  logic [31:0]                    angle;
  logic                           keep;
  logic signed [31:0]             angle_s;
  logic                           flip;
  logic [31:0]                    z_fold;

  logic                           a_valid_q;
  logic                           a_flip_q;
  logic [30:0]                    a_range_q;
  logic signed [srcp_pkg::Z_W-1:0] a_z_q;

  logic [62:0]                    product;
  logic [62:0]                    product_rnd;

  logic                           b_valid_q;
  logic                           b_flip_q;
  logic signed [srcp_pkg::XY_W-1:0] b_x_q;
  logic signed [srcp_pkg::Z_W-1:0]  b_z_q;

  assign angle        = in_word_i.scan_start ? cfg_i.start_angle : beam_angle_q;
  assign beam_angle_d = angle + cfg_i.angle_step;
  assign keep         = (in_word_i.range_sample >= cfg_i.min_range) &&
                        (in_word_i.range_sample <= cfg_i.max_range);

  // fold angles outside the right half plane by half a turn
  assign angle_s = $signed(angle);
  assign flip    = (angle_s > srcp_pkg::QUARTER_TURN) || (angle_s < -srcp_pkg::QUARTER_TURN);
  assign z_fold  = flip ? (angle ^ 32'h8000_0000) : angle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_angle_q <= '0;
      a_valid_q    <= 1'b0;
      b_valid_q    <= 1'b0;
    end else begin
      if (accept_i) begin
        beam_angle_q <= beam_angle_d;
      end
      if (en_i) begin
        a_valid_q <= accept_i && keep;
        b_valid_q <= a_valid_q;
      end
    end
  end

  // range times gain, rounded to 24 fraction bits
  assign product     = 63'(a_range_q) * 63'(srcp_pkg::GAIN_Q32);
  assign product_rnd = product + 63'(1 << 23);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_flip_q  <= flip;
      a_range_q <= in_word_i.range_sample;
      a_z_q     <= srcp_pkg::Z_W'($signed(z_fold));
      b_flip_q  <= a_flip_q;
      b_z_q     <= a_z_q;
      b_x_q     <= $signed({{(srcp_pkg::XY_W - 39){1'b0}}, product_rnd[62:24]});
    end
  end

  assign out_o.valid = b_valid_q;
  assign out_o.flip  = b_flip_q;
  assign out_o.x     = b_x_q;
  assign out_o.y     = '0;
  assign out_o.z     = b_z_q;

endmodule

### rtl/srcp_cell.sv
// srcp_cell: one cordic rotation stage, shift and arctangent fixed by SHIFT
// registered, hands its word to the next cell
// depends on srcp_pkg
`timescale 1ns / 1ps

module srcp_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  srcp_pkg::cordic_word_t in_i,
  output srcp_pkg::cordic_word_t out_o
);

  localparam logic signed [srcp_pkg::Z_W-1:0] ATAN =
    srcp_pkg::Z_W'($signed({1'b0, srcp_pkg::ATAN_TABLE[SHIFT]}));

  logic signed [srcp_pkg::XY_W-1:0] x_in, y_in, xs, ys;
  logic signed [srcp_pkg::Z_W-1:0]  z_in;
  srcp_pkg::cordic_word_t           word_d;

  logic                             valid_q;
  logic                             flip_q;
  logic signed [srcp_pkg::XY_W-1:0] x_q, y_q;
  logic signed [srcp_pkg::Z_W-1:0]  z_q;

  assign x_in = in_i.x;
  assign y_in = in_i.y;
  assign z_in = in_i.z;
  assign xs   = x_in >>> SHIFT;
  assign ys   = y_in >>> SHIFT;

  always_comb begin
    word_d.valid = in_i.valid;
    word_d.flip  = in_i.flip;
    // non-negative residual rotates forward
    if (!z_in[srcp_pkg::Z_W-1]) begin
      word_d.x = x_in - ys;
      word_d.y = y_in + xs;
      word_d.z = z_in - ATAN;
    end else begin
      word_d.x = x_in + ys;
      word_d.y = y_in - xs;
      word_d.z = z_in + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= word_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flip_q <= word_d.flip;
      x_q    <= word_d.x;
      y_q    <= word_d.y;
      z_q    <= word_d.z;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.flip  = flip_q;
  assign out_o.x     = x_q;
  assign out_o.y     = y_q;
  assign out_o.z     = z_q;

endmodule

### rtl/srcp_finish.sv
// srcp_finish: undo the half-turn fold, round off guard bits, saturate to 32 bits
// one register stage after the last cordic cell
// depends on srcp_pkg
`timescale 1ns / 1ps

module srcp_finish (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  srcp_pkg::cordic_word_t in_i,
  output logic                   valid_o,
  output srcp_pkg::out_word_t    word_o
);

  localparam int unsigned SUM_W = srcp_pkg::XY_W + 1;
  localparam int unsigned RES_W = SUM_W - srcp_pkg::GUARD_BITS;

  function automatic logic signed [31:0] round_sat(input logic signed [srcp_pkg::XY_W-1:0] v,
                                                   input logic flip);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] sum;
    logic signed [RES_W-1:0] r;
    logic signed [31:0]      res;
    s   = flip ? -SUM_W'(v) : SUM_W'(v);
    sum = s + SUM_W'(1 << (srcp_pkg::GUARD_BITS - 1));
    r   = sum[SUM_W-1:srcp_pkg::GUARD_BITS];
    if (r > RES_W'(32'sh7FFF_FFFF)) begin
      res = 32'sh7FFF_FFFF;
    end else if (r < -RES_W'(33'sh0_8000_0000)) begin
      res = 32'sh8000_0000;
    end else begin
      res = r[31:0];
    end
    return res;
  endfunction

  logic                valid_q;
  srcp_pkg::out_word_t word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q.point_x <= round_sat(in_i.x, in_i.flip);
      word_q.point_y <= round_sat(in_i.y, in_i.flip);
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

### rtl/scan_range_to_cartesian_point_unit.sv
// scan_range_to_cartesian_point_unit: top level, lidar range sample to x/y point
// config registers, front stages, cordic cell chain, finish stage, output buffer
// depends on srcp_pkg, srcp_front, srcp_cell, srcp_finish
`timescale 1ns / 1ps

// usage
// - input channel: one range sample per word (in_valid_i / in_stall_o / in_word_i),
//   scan_start restarts the beam angle at start_angle; every word, kept or
//   dropped, advances the beam angle by angle_step
// - output channel: one x/y point per kept word (out_valid_o / out_stall_i /
//   out_word_o); words with range outside [min_range, max_range] give nothing
// - config: cfg_we_i writes cfg_data_i to the register at cfg_idx_i (0 start_angle,
//   1 angle_step, 2 min_range, 3 max_range), user writes only while idle, unenforced
// - throughput: one word per cycle while not stalled, set by the fully pipelined
//   chain of CORDIC_STAGES rotation cells
// - path: the edge that accepts a sample loads the first front stage; then the
//   second front stage, the cells, finish and the output register follow, and
//   the point shows on out_valid_o once the output register holds it
// - stall: the output register is backed by a one-word skid buffer; the
//   pipeline freezes only once the skid is full, and in_stall_o is the
//   registered skid-full flag, so the skid word absorbs a point finished while held
// - reset: angle and ranges return to their reset values (start 0, step 0,
//   min 0, max 2^31-1), beam angle 0, all pipeline words invalid

module scan_range_to_cartesian_point_unit #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srcp_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srcp_pkg::out_word_t out_word_o
);

  srcp_pkg::cfg_t cfg_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_angle <= '0;
      cfg_q.angle_step  <= '0;
      cfg_q.min_range   <= '0;
      cfg_q.max_range   <= 31'h7FFF_FFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srcp_pkg::CFG_START_ANGLE: cfg_q.start_angle <= cfg_data_i;
        srcp_pkg::CFG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_data_i;
        srcp_pkg::CFG_MIN_RANGE:   cfg_q.min_range   <= cfg_data_i[30:0];
        srcp_pkg::CFG_MAX_RANGE:   cfg_q.max_range   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances together unless the skid word is waiting
  logic pipe_en;
  logic in_accept;
  logic skid_valid_q, skid_valid_d;

  assign pipe_en    = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;

  srcp_pkg::cordic_word_t chain [CORDIC_STAGES+1];

  srcp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (pipe_en),
    .accept_i  (in_accept),
    .in_word_i (in_word_i),
    .cfg_i     (cfg_q),
    .out_o     (chain[0])
  );

  // one cell per cordic iteration, cell k shifts by k
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    srcp_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .in_i   (chain[k]),
      .out_o  (chain[k+1])
    );
  end

  logic                fin_valid;
  srcp_pkg::out_word_t fin_word;

  srcp_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .in_i    (chain[CORDIC_STAGES]),
    .valid_o (fin_valid),
    .word_o  (fin_word)
  );

  // output register plus skid word
  logic                main_valid_q, main_valid_d;
  srcp_pkg::out_word_t main_word_q, main_word_d;
  srcp_pkg::out_word_t skid_word_q, skid_word_d;
  logic                out_take;

  assign out_take = main_valid_q && !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    main_word_d  = main_word_q;
    skid_valid_d = skid_valid_q;
    skid_word_d  = skid_word_q;
    if (pipe_en && fin_valid) begin
      if (!main_valid_q || out_take) begin
        main_valid_d = 1'b1;
        main_word_d  = fin_word;
      end else begin
        // receiver holding the current point: park the new one
        skid_valid_d = 1'b1;
        skid_word_d  = fin_word;
      end
    end else if (skid_valid_q && out_take) begin
      main_word_d  = skid_word_q;
      skid_valid_d = 1'b0;
    end else if (out_take) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_word_q <= main_word_d;
    skid_word_q <= skid_word_d;
  end

  assign out_valid_o = main_valid_q;
  assign out_word_o  = main_word_q;

  // a parked word always has a word ahead of it in the output register
  a_skid_behind_main : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid word without output word");

  // the skid only fills when the output register was held by the receiver
  a_skid_fill_on_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(main_valid_q && out_stall_i))
    else $error("skid filled without a held output word");

  // a frozen pipeline keeps its finished word
  a_freeze_holds_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(fin_valid))
    else $error("finish stage moved while pipeline frozen");

endmodule
